FILE: hdl/ctb_pkg.sv
// ----------------------------------------------------------------------------
// ctb_pkg
// Shared constants, operation and status codes, and item types for the
// cursor text buffer.
// ----------------------------------------------------------------------------
package ctb_pkg;

   localparam int CAPACITY = 32;
   localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int COUNT_W  = 6;
   localparam int CHAR_W   = 8;
   localparam int MODE_W   = 3;
   localparam int STATUS_W = 2;

   localparam logic [MODE_W-1:0] MODE_INSERT = 3'd0;
   localparam logic [MODE_W-1:0] MODE_DELETE = 3'd1;
   localparam logic [MODE_W-1:0] MODE_LEFT   = 3'd2;
   localparam logic [MODE_W-1:0] MODE_RIGHT  = 3'd3;
   localparam logic [MODE_W-1:0] MODE_READ   = 3'd4;

   localparam logic [STATUS_W-1:0] STATUS_DONE      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NO_EFFECT = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;

   localparam logic [CHAR_W-1:0] MARKER_CHAR = 8'h7C;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [CHAR_W-1:0] char_value;
   } req_type;

   typedef struct packed {
      logic [CHAR_W-1:0]   char_value_out;
      logic                is_marker;
      logic [STATUS_W-1:0] status;
      logic [COUNT_W-1:0]  text_length;
      logic [COUNT_W-1:0]  cursor_pos;
      logic                last;
   } rsp_type;

   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [CHAR_W-1:0] wr_data;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
   } ram_ctl_type;

endpackage

FILE: hdl/ctb_ram.sv
// ----------------------------------------------------------------------------
// ctb_ram
// One character stack store: one write port, one read port, registered
// read data that holds while no read is issued.
// ----------------------------------------------------------------------------
module ctb_ram
   import ctb_pkg::*;
(
   input  logic              clock,
   input  ram_ctl_type       ctl,
   output logic [CHAR_W-1:0] rd_data
);

   logic [CHAR_W-1:0] mem [CAPACITY];
   logic [CHAR_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[ctl.wr_addr] <= ctl.wr_data;
      end
      if (ctl.rd_en) begin
         rd_data_ff <= mem[ctl.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/cursor_text_buffer.sv
// ----------------------------------------------------------------------------
// cursor_text_buffer
// Text edit buffer with a cursor, held as two character stacks in two
// synchronous stores, with edit and readout sequencing.
// ----------------------------------------------------------------------------
//   channel   direction   handshake              payload
//   req_      in          req_valid / req_stall  req_data (req_type)
//   rsp_      out         rsp_valid / rsp_stall  rsp_data (rsp_type)
//
// insert, delete and unused codes answer from the execute state; moves read the
// source stack first, then write back on the other stack (no read at a boundary).
// readout issues one store read per character item, plus the cursor marker item.
// one item is worked on at a time; the result register frees the input side.
// reset clears both counts; store contents are undefined until written.
// rsp_stall holds the sequencer in place; no item is dropped.
// ----------------------------------------------------------------------------
module cursor_text_buffer
   import ctb_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_MOVE,
      S_READ_L,
      S_MARK,
      S_READ_R
   } state_type;

   state_type          state_ff, state_in;
   req_type            req_ff, req_in;
   logic [COUNT_W-1:0] lc_ff, lc_in;
   logic [COUNT_W-1:0] rc_ff, rc_in;
   logic [ADDR_W-1:0]  idx_ff, idx_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   ram_ctl_type        left_ctl, right_ctl;
   logic [CHAR_W-1:0]  left_rd, right_rd;

   logic               out_free;
   logic [COUNT_W:0]   sum;
   logic [COUNT_W-1:0] lc_m1, rc_m1, lc_p1, rc_p1, idx_p1;

   function automatic rsp_type make_rsp(input logic [CHAR_W-1:0] ch,
                                        input logic marker,
                                        input logic [STATUS_W-1:0] st,
                                        input logic [COUNT_W-1:0] lc,
                                        input logic [COUNT_W-1:0] rc,
                                        input logic lst);
      rsp_type r;
      r.char_value_out = ch;
      r.is_marker      = marker;
      r.status         = st;
      r.text_length    = lc + rc;
      r.cursor_pos     = lc;
      r.last           = lst;
      return r;
   endfunction

   ctb_ram u_left (
      .clock   (clock),
      .ctl     (left_ctl),
      .rd_data (left_rd)
   );

   ctb_ram u_right (
      .clock   (clock),
      .ctl     (right_ctl),
      .rd_data (right_rd)
   );

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign sum       = {1'b0, lc_ff} + {1'b0, rc_ff};
   assign lc_m1     = lc_ff - COUNT_W'(1);
   assign rc_m1     = rc_ff - COUNT_W'(1);
   assign lc_p1     = lc_ff + COUNT_W'(1);
   assign rc_p1     = rc_ff + COUNT_W'(1);
   assign idx_p1    = COUNT_W'(idx_ff) + COUNT_W'(1);
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      lc_in        = lc_ff;
      rc_in        = rc_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      left_ctl     = '0;
      right_ctl    = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in   = req_data;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            case (req_ff.mode)
               MODE_INSERT: begin
                  if (out_free) begin
                     rsp_valid_in = 1'b1;
                     state_in     = S_IDLE;
                     if (sum >= (COUNT_W+1)'(CAPACITY)) begin
                        rsp_in = make_rsp('0, 1'b0, STATUS_FULL, lc_ff, rc_ff, 1'b1);
                     end else begin
                        left_ctl.wr_en   = 1'b1;
                        left_ctl.wr_addr = lc_ff[ADDR_W-1:0];
                        left_ctl.wr_data = req_ff.char_value;
                        lc_in            = lc_p1;
                        rsp_in = make_rsp('0, 1'b0, STATUS_DONE, lc_p1, rc_ff, 1'b1);
                     end
                  end
               end
               MODE_DELETE: begin
                  if (out_free) begin
                     rsp_valid_in = 1'b1;
                     state_in     = S_IDLE;
                     if (lc_ff == '0) begin
                        rsp_in = make_rsp('0, 1'b0, STATUS_NO_EFFECT, lc_ff, rc_ff, 1'b1);
                     end else begin
                        lc_in  = lc_m1;
                        rsp_in = make_rsp('0, 1'b0, STATUS_DONE, lc_m1, rc_ff, 1'b1);
                     end
                  end
               end
               MODE_LEFT: begin
                  if (lc_ff == '0 || rc_ff >= COUNT_W'(CAPACITY)) begin
                     if (out_free) begin
                        rsp_valid_in = 1'b1;
                        state_in     = S_IDLE;
                        rsp_in = make_rsp('0, 1'b0, STATUS_NO_EFFECT, lc_ff, rc_ff, 1'b1);
                     end
                  end else begin
                     left_ctl.rd_en   = 1'b1;
                     left_ctl.rd_addr = lc_m1[ADDR_W-1:0];
                     state_in         = S_MOVE;
                  end
               end
               MODE_RIGHT: begin
                  if (rc_ff == '0 || lc_ff >= COUNT_W'(CAPACITY)) begin
                     if (out_free) begin
                        rsp_valid_in = 1'b1;
                        state_in     = S_IDLE;
                        rsp_in = make_rsp('0, 1'b0, STATUS_NO_EFFECT, lc_ff, rc_ff, 1'b1);
                     end
                  end else begin
                     right_ctl.rd_en   = 1'b1;
                     right_ctl.rd_addr = rc_m1[ADDR_W-1:0];
                     state_in          = S_MOVE;
                  end
               end
               MODE_READ: begin
                  if (lc_ff != '0) begin
                     left_ctl.rd_en   = 1'b1;
                     left_ctl.rd_addr = '0;
                     idx_in           = '0;
                     state_in         = S_READ_L;
                  end else begin
                     state_in = S_MARK;
                  end
               end
               default: begin
                  if (out_free) begin
                     rsp_valid_in = 1'b1;
                     state_in     = S_IDLE;
                     rsp_in = make_rsp('0, 1'b0, STATUS_NO_EFFECT, lc_ff, rc_ff, 1'b1);
                  end
               end
            endcase
         end
         S_MOVE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
               if (req_ff.mode == MODE_LEFT) begin
                  right_ctl.wr_en   = 1'b1;
                  right_ctl.wr_addr = rc_ff[ADDR_W-1:0];
                  right_ctl.wr_data = left_rd;
                  lc_in             = lc_m1;
                  rc_in             = rc_p1;
                  rsp_in = make_rsp('0, 1'b0, STATUS_DONE, lc_m1, rc_p1, 1'b1);
               end else begin
                  left_ctl.wr_en   = 1'b1;
                  left_ctl.wr_addr = lc_ff[ADDR_W-1:0];
                  left_ctl.wr_data = right_rd;
                  lc_in            = lc_p1;
                  rc_in            = rc_m1;
                  rsp_in = make_rsp('0, 1'b0, STATUS_DONE, lc_p1, rc_m1, 1'b1);
               end
            end
         end
         S_READ_L: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in = make_rsp(left_rd, 1'b0, STATUS_DONE, lc_ff, rc_ff, 1'b0);
               if (idx_p1 < lc_ff) begin
                  left_ctl.rd_en   = 1'b1;
                  left_ctl.rd_addr = idx_p1[ADDR_W-1:0];
                  idx_in           = idx_p1[ADDR_W-1:0];
               end else begin
                  state_in = S_MARK;
               end
            end
         end
         S_MARK: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in = make_rsp(MARKER_CHAR, 1'b1, STATUS_DONE, lc_ff, rc_ff,
                                 rc_ff == '0);
               if (rc_ff != '0) begin
                  right_ctl.rd_en   = 1'b1;
                  right_ctl.rd_addr = rc_m1[ADDR_W-1:0];
                  idx_in            = rc_m1[ADDR_W-1:0];
                  state_in          = S_READ_R;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_READ_R: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in = make_rsp(right_rd, 1'b0, STATUS_DONE, lc_ff, rc_ff,
                                 idx_ff == '0);
               if (idx_ff != '0) begin
                  right_ctl.rd_en   = 1'b1;
                  right_ctl.rd_addr = idx_ff - ADDR_W'(1);
                  idx_in            = idx_ff - ADDR_W'(1);
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         lc_ff        <= '0;
         rc_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         lc_ff        <= lc_in;
         rc_ff        <= rc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff <= req_in;
      idx_ff <= idx_in;
      rsp_ff <= rsp_in;
   end

`ifndef SYNTHESIS
   a_capacity: assert property (@(posedge clock) disable iff (reset)
      sum <= (COUNT_W+1)'(CAPACITY))
      else $error("text length above capacity");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> (lc_ff == $past(lc_ff) || lc_ff == $past(lc_ff) + COUNT_W'(1)
                || lc_ff + COUNT_W'(1) == $past(lc_ff)))
      else $error("cursor moved by more than one");

   a_edit_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.status != STATUS_DONE |-> rsp_ff.last && !rsp_ff.is_marker)
      else $error("edit status item not flagged last");

   a_marker: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.is_marker |->
         rsp_ff.char_value_out == MARKER_CHAR && rsp_ff.status == STATUS_DONE)
      else $error("bad cursor marker item");

   a_no_write_clash: assert property (@(posedge clock) disable iff (reset)
      !(left_ctl.wr_en && right_ctl.wr_en))
      else $error("both stacks written in one cycle");
`endif

endmodule
